// ===== src/trp_pkg.sv =====
package trp_pkg;

    // Default position resolution in bits (range 8 to 16).
    localparam int POS_WIDTH_DEFAULT = 16;

    // Configuration port geometry.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_THRESHOLD   = 2'd0;
    localparam logic [1:0] REG_IDLE_LIMIT  = 2'd1;
    localparam logic [1:0] REG_DEVICE_CODE = 2'd2;

    // Register reset values.
    localparam logic [7:0]  RESET_THRESHOLD   = 8'd10;
    localparam logic [15:0] RESET_IDLE_LIMIT  = 16'd150;
    localparam logic [7:0]  RESET_DEVICE_CODE = 8'h55;

    // Fixed terms of the report checksum.
    localparam logic [15:0] REPORT_ID    = 16'd1;
    localparam logic [15:0] REPORT_BYTES = 16'd5;
    localparam logic [15:0] MOUSE_TYPE   = 16'd1;

    localparam logic [15:0] IDLE_MAX = 16'hFFFF;

    // Configuration register contents.
    typedef struct packed {
        logic [7:0]  double_threshold;
        logic [15:0] idle_limit;
        logic [7:0]  device_code;
    } cfg_t;

    // One scan result.
    typedef struct packed {
        logic        finger_down;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic        left_down;
        logic        right_down;
        logic        gang_down;
    } scan_t;

    // One mouse report.
    typedef struct packed {
        logic        report_valid;
        logic [1:0]  click_bits;
        logic [7:0]  delta_x;
        logic [7:0]  delta_y;
        logic [1:0]  sign_bits;
        logic [15:0] checksum;
        logic        fast_mode;
    } result_t;

endpackage

// ===== src/trp_regs.sv =====
module trp_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [trp_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [trp_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [trp_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output trp_pkg::cfg_t                   cfg
);
    import trp_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg     = cfg_reg;

    // Register write decode; writes to unused addresses are dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_THRESHOLD:   cfg_next.double_threshold = pwdata[7:0];
                REG_IDLE_LIMIT:  cfg_next.idle_limit       = pwdata[15:0];
                REG_DEVICE_CODE: cfg_next.device_code      = pwdata[7:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.double_threshold <= RESET_THRESHOLD;
            cfg_reg.idle_limit       <= RESET_IDLE_LIMIT;
            cfg_reg.device_code      <= RESET_DEVICE_CODE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read data multiplexer.
    always_comb
    begin
        unique case (reg_idx)
            REG_THRESHOLD:   prdata = APB_DATA_W'(cfg_reg.double_threshold);
            REG_IDLE_LIMIT:  prdata = APB_DATA_W'(cfg_reg.idle_limit);
            REG_DEVICE_CODE: prdata = APB_DATA_W'(cfg_reg.device_code);
            default:         prdata = '0;
        endcase
    end

endmodule

// ===== src/trp_motion.sv =====
module trp_motion #(
    parameter int POS_WIDTH = trp_pkg::POS_WIDTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  trp_pkg::scan_t   scan,
    input  trp_pkg::cfg_t    cfg,
    output trp_pkg::result_t result
);
    import trp_pkg::*;

    logic                 mode_fast_reg,   mode_fast_next;
    logic [15:0]          idle_count_reg,  idle_count_next;
    logic [POS_WIDTH-1:0] last_x_reg,      last_x_next;
    logic [POS_WIDTH-1:0] last_y_reg,      last_y_next;
    logic                 last_finger_reg, last_finger_next;
    logic                 last_left_reg,   last_left_next;
    logic                 last_right_reg,  last_right_next;

    logic [POS_WIDTH-1:0] px, py;
    logic [POS_WIDTH-1:0] dx_raw, dy_raw;
    logic                 held, x_dec, y_dec, active, report;
    logic [1:0]           clicks, signs;
    logic [7:0]           dx, dy;
    logic [15:0]          idle_inc;

    // A delta above the threshold is doubled; only the low byte is kept.
    function automatic logic [7:0] scale_delta(input logic [POS_WIDTH-1:0] d,
                                               input logic [7:0] thr);
        logic [7:0] r;
        if (d > POS_WIDTH'(thr))
            r = {d[6:0], 1'b0};
        else
            r = d[7:0];
        return r;
    endfunction

    // Position and motion; a lifted finger reads as the origin.
    always_comb
    begin
        px     = scan.finger_down ? scan.pos_x[POS_WIDTH-1:0] : '0;
        py     = scan.finger_down ? scan.pos_y[POS_WIDTH-1:0] : '0;
        held   = scan.finger_down && last_finger_reg;
        x_dec  = last_x_reg > px;
        y_dec  = last_y_reg > py;
        dx_raw = x_dec ? (last_x_reg - px) : (px - last_x_reg);
        dy_raw = y_dec ? (last_y_reg - py) : (py - last_y_reg);
        if (!held)
        begin
            dx_raw = '0;
            dy_raw = '0;
        end
        dx     = scale_delta(dx_raw, cfg.double_threshold);
        dy     = scale_delta(dy_raw, cfg.double_threshold);
        signs  = {held && x_dec, held && !y_dec};
        clicks = {scan.right_down && !last_right_reg, scan.left_down && !last_left_reg};
        report = scan.finger_down || (clicks != 2'b00);
        active = scan.finger_down || scan.left_down || scan.right_down || scan.gang_down;
        idle_inc = (idle_count_reg == IDLE_MAX) ? idle_count_reg : idle_count_reg + 16'd1;
    end

    // Report assembly and next state.
    always_comb
    begin
        mode_fast_next   = mode_fast_reg;
        idle_count_next  = idle_count_reg;
        last_x_next      = last_x_reg;
        last_y_next      = last_y_reg;
        last_finger_next = last_finger_reg;
        last_left_next   = last_left_reg;
        last_right_next  = last_right_reg;
        result           = '0;

        if (mode_fast_reg)
        begin
            last_x_next      = px;
            last_y_next      = py;
            last_finger_next = scan.finger_down;
            last_left_next   = scan.left_down;
            last_right_next  = scan.right_down;
            if (report)
            begin
                result.report_valid = 1'b1;
                result.click_bits   = clicks;
                result.delta_x      = dx;
                result.delta_y      = dy;
                result.sign_bits    = signs;
                result.checksum     = REPORT_ID + 16'(cfg.device_code) + REPORT_BYTES
                                    + MOUSE_TYPE + 16'(clicks) + 16'(dy) + 16'(dx)
                                    + 16'(signs);
            end
            if (active)
            begin
                idle_count_next = '0;
            end
            else
            begin
                idle_count_next = idle_inc;
                if (idle_inc >= cfg.idle_limit)
                    mode_fast_next = 1'b0;
            end
        end
        else if (scan.gang_down)
        begin
            mode_fast_next  = 1'b1;
            idle_count_next = '0;
        end

        result.fast_mode = mode_fast_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_fast_reg   <= 1'b1;
            idle_count_reg  <= '0;
            last_x_reg      <= '1;
            last_y_reg      <= '0;
            last_finger_reg <= 1'b0;
            last_left_reg   <= 1'b0;
            last_right_reg  <= 1'b0;
        end
        else if (step)
        begin
            mode_fast_reg   <= mode_fast_next;
            idle_count_reg  <= idle_count_next;
            last_x_reg      <= last_x_next;
            last_y_reg      <= last_y_next;
            last_finger_reg <= last_finger_next;
            last_left_reg   <= last_left_next;
            last_right_reg  <= last_right_next;
        end
    end

`ifndef SYNTHESIS
    // Slow scans never produce a report.
    a_slow_no_report: assert property (@(posedge clk) disable iff (!rst_n)
        step && !mode_fast_reg |-> !result.report_valid)
        else $error("report produced in slow mode");

    // Without a report the checksum, click bits and sign bits are cleared.
    a_no_report_zero: assert property (@(posedge clk) disable iff (!rst_n)
        step && !result.report_valid |-> (result.checksum == 16'd0)
            && (result.click_bits == 2'b00) && (result.sign_bits == 2'b00))
        else $error("report fields not cleared");

    // Slow mode is only entered once the idle count reaches the limit.
    a_slow_entry: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(mode_fast_reg) |-> (idle_count_reg >= $past(cfg.idle_limit)))
        else $error("slow mode entered before idle limit");
`endif

endmodule

// ===== src/trackpad_relative_motion_reporter_core.sv =====
// Trackpad relative-motion reporter.
// Input channel: in_valid/in_stall with one scan item (finger, position,
// buttons, ganged sensor). Output channel: out_valid/out_stall with one
// report item per scan (report fields plus the current scan mode).
// An item is taken at a rising edge where valid is high and stall is low.
// The scan is held in an input register, and the report is computed in one
// pass and held in a result register. Throughput is one item per cycle
// while the receiver does not stall; the motion state (last position,
// buttons, idle count, mode) is updated in that same single pass.
// When the receiver stalls, the result register holds its item and the
// input register can still take one more; in_stall rises only when both
// are full.
// Configuration registers (threshold, idle limit, device code) are to be
// written over the APB port by the user only while no item is in flight;
// the block does not enforce this. Reset clears both valid flags and puts
// the block in fast mode with the register defaults loaded.
module trackpad_relative_motion_reporter_core #(
    parameter int POS_WIDTH = trp_pkg::POS_WIDTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [trp_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [trp_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [trp_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            finger_down,
    input  logic [15:0]                     pos_x,
    input  logic [15:0]                     pos_y,
    input  logic                            left_down,
    input  logic                            right_down,
    input  logic                            gang_down,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            report_valid,
    output logic [1:0]                      click_bits,
    output logic [7:0]                      delta_x,
    output logic [7:0]                      delta_y,
    output logic [1:0]                      sign_bits,
    output logic [15:0]                     checksum,
    output logic                            fast_mode
);
    import trp_pkg::*;

    cfg_t    cfg;
    scan_t   scan_reg, scan_next;
    result_t res_comb;
    result_t res_reg, res_next;
    logic    in_valid_reg, in_valid_next;
    logic    out_valid_reg, out_valid_next;
    logic    out_free, move, accept;

    trp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Handshake: the scan moves on whenever the result register is free.
    assign out_free = !out_valid_reg || !out_stall;
    assign move     = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        scan_next.finger_down = finger_down;
        scan_next.pos_x       = pos_x;
        scan_next.pos_y       = pos_y;
        scan_next.left_down   = left_down;
        scan_next.right_down  = right_down;
        scan_next.gang_down   = gang_down;
        in_valid_next  = accept || (in_valid_reg && !move);
        out_valid_next = move || (out_valid_reg && out_stall);
        res_next       = move ? res_comb : res_reg;
    end

    trp_motion #(
        .POS_WIDTH (POS_WIDTH)
    ) u_motion (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (move),
        .scan   (scan_reg),
        .cfg    (cfg),
        .result (res_comb)
    );

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
            scan_reg <= scan_next;
        res_reg <= res_next;
    end

    assign out_valid    = out_valid_reg;
    assign report_valid = res_reg.report_valid;
    assign click_bits   = res_reg.click_bits;
    assign delta_x      = res_reg.delta_x;
    assign delta_y      = res_reg.delta_y;
    assign sign_bits    = res_reg.sign_bits;
    assign checksum     = res_reg.checksum;
    assign fast_mode    = res_reg.fast_mode;

`ifndef SYNTHESIS
    // A scan only moves on when the result register can take it.
    a_move_room: assert property (@(posedge clk) disable iff (!rst_n)
        move |-> (!out_valid_reg || !out_stall))
        else $error("scan overwrote a pending report");
`endif

endmodule

// ===== verif/tb_trackpad_relative_motion_reporter_core.sv =====
`timescale 1ns / 1ps

module tb_trackpad_relative_motion_reporter_core;
    import trp_pkg::*;

    localparam int POS_W = POS_WIDTH_DEFAULT;
    localparam logic [15:0] POS_MASK = 16'((32'd1 << POS_W) - 32'd1);

    typedef enum logic [1:0] {
        SEQ_GESTURE,
        SEQ_CLICKS,
        SEQ_IDLE_RUN,
        SEQ_NOISE
    } seq_kind_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  finger_down = 1'b0;
    logic [15:0]           pos_x = '0;
    logic [15:0]           pos_y = '0;
    logic                  left_down = 1'b0;
    logic                  right_down = 1'b0;
    logic                  gang_down = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  report_valid;
    logic [1:0]            click_bits;
    logic [7:0]            delta_x;
    logic [7:0]            delta_y;
    logic [1:0]            sign_bits;
    logic [15:0]           checksum;
    logic                  fast_mode;

    // Pacing controls shared by the sender and the receiver.
    bit          tx_gaps_on = 1'b0;
    bit          rx_stall_on = 1'b0;
    int unsigned holdoff_request = 0;
    int unsigned scans_sent = 0;
    int unsigned mismatch_count = 0;

    // Reports still to come out of the block, oldest first.
    result_t expected_reports[$];

    // Shadow copy of the registers and of the motion tracking state.
    cfg_t        cfg_shadow = '{RESET_THRESHOLD, RESET_IDLE_LIMIT, RESET_DEVICE_CODE};
    logic        trk_fast = 1'b1;
    logic [15:0] trk_idle = '0;
    logic [15:0] trk_x = 16'hFFFF & POS_MASK;
    logic [15:0] trk_y = '0;
    logic        trk_finger = 1'b0;
    logic        trk_left = 1'b0;
    logic        trk_right = 1'b0;

    trackpad_relative_motion_reporter_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .finger_down  (finger_down),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .left_down    (left_down),
        .right_down   (right_down),
        .gang_down    (gang_down),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .report_valid (report_valid),
        .click_bits   (click_bits),
        .delta_x      (delta_x),
        .delta_y      (delta_y),
        .sign_bits    (sign_bits),
        .checksum     (checksum),
        .fast_mode    (fast_mode)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #(25_000_000);
        $display("Mismatches found");
        $finish;
    end

    // A delta above the threshold is doubled; only the low byte survives.
    function automatic logic [7:0] scale_delta(logic [15:0] d);
        logic [16:0] t;
        t = (d > 16'(cfg_shadow.double_threshold)) ? {d, 1'b0} : {1'b0, d};
        return t[7:0];
    endfunction

    // Works out the report for one scan and advances the tracking state.
    function automatic result_t compute_report(scan_t s);
        result_t     r;
        logic [15:0] px;
        logic [15:0] py;
        logic [15:0] dx;
        logic [15:0] dy;
        logic [1:0]  clicks;
        logic [1:0]  signs;
        r = '0;
        dx = '0;
        dy = '0;
        clicks = '0;
        signs = '0;
        px = s.pos_x & POS_MASK;
        py = s.pos_y & POS_MASK;
        if (trk_fast)
        begin
            if (!s.finger_down)
            begin
                px = '0;
                py = '0;
            end
            // Motion only counts while the touch is held across two scans.
            if (s.finger_down && trk_finger)
            begin
                if (trk_x > px)
                begin
                    dx = trk_x - px;
                    signs[1] = 1'b1;
                end
                else
                begin
                    dx = px - trk_x;
                end
                if (trk_y > py)
                begin
                    dy = trk_y - py;
                end
                else
                begin
                    dy = py - trk_y;
                    signs[0] = 1'b1;
                end
            end
            trk_x = px;
            trk_y = py;
            clicks[0] = s.left_down && !trk_left;
            clicks[1] = s.right_down && !trk_right;
            trk_finger = s.finger_down;
            trk_left = s.left_down;
            trk_right = s.right_down;
            if (s.finger_down || clicks != 2'b00)
            begin
                r.report_valid = 1'b1;
                r.click_bits = clicks;
                r.delta_x = scale_delta(dx);
                r.delta_y = scale_delta(dy);
                r.sign_bits = signs;
                r.checksum = REPORT_ID + 16'(cfg_shadow.device_code) + REPORT_BYTES
                           + MOUSE_TYPE + 16'(clicks) + 16'(r.delta_y) + 16'(r.delta_x)
                           + 16'(signs);
            end
            // Idle scans count towards the drop into slow mode.
            if (!(s.finger_down || s.left_down || s.right_down || s.gang_down))
            begin
                if (trk_idle < IDLE_MAX)
                    trk_idle = trk_idle + 16'd1;
                if (trk_idle >= cfg_shadow.idle_limit)
                    trk_fast = 1'b0;
            end
            else
            begin
                trk_idle = '0;
            end
        end
        else if (s.gang_down)
        begin
            trk_fast = 1'b1;
            trk_idle = '0;
        end
        r.fast_mode = trk_fast;
        return r;
    endfunction

    function automatic scan_t scan_item(logic f, logic [15:0] x, logic [15:0] y,
                                        logic l, logic r, logic g);
        scan_t s;
        s.finger_down = f;
        s.pos_x = x;
        s.pos_y = y;
        s.left_down = l;
        s.right_down = r;
        s.gang_down = g;
        return s;
    endfunction

    // Mostly no pause, often a short one, now and then a long one.
    function automatic int unsigned pick_pause();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    function automatic logic [15:0] rand_position();
        logic [15:0] p;
        if ($urandom_range(0, 3) == 0)
        begin
            case ($urandom_range(0, 5))
                0:       p = 16'h0000;
                1:       p = 16'h0001;
                2:       p = 16'h7FFF;
                3:       p = 16'h8000;
                4:       p = 16'hFFFE;
                default: p = 16'hFFFF;
            endcase
        end
        else
        begin
            p = 16'($urandom);
        end
        return p;
    endfunction

    // Moves a coordinate by a step that is usually near the threshold.
    function automatic logic [15:0] step_position(logic [15:0] p);
        logic [15:0] mag;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            mag = 16'($urandom_range(0, 24));
        else if (pick < 92)
            mag = 16'($urandom_range(0, 400));
        else
            mag = 16'($urandom);
        return ($urandom_range(0, 1) != 0) ? p + mag : p - mag;
    endfunction

    // Offers one scan item and waits until the block takes it.
    task automatic send_scan(scan_t s);
        int unsigned gap;
        logic        taken;
        gap = tx_gaps_on ? pick_pause() : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        finger_down <= s.finger_down;
        pos_x <= s.pos_x;
        pos_y <= s.pos_y;
        left_down <= s.left_down;
        right_down <= s.right_down;
        gang_down <= s.gang_down;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
        expected_reports.push_back(compute_report(s));
        scans_sent++;
    endtask

    // Stops offering items and lets every outstanding report come out.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes one register over the APB port, then reads it back.
    task automatic write_register(logic [1:0] idx, logic [31:0] value);
        logic [31:0] width_mask;
        logic [31:0] readback;
        logic        done;
        wait_drained();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(negedge clk);
            done = pready;
            @(posedge clk);
        end
        while (!done);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(negedge clk);
            done = pready;
            readback = prdata;
            @(posedge clk);
        end
        while (!done);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_THRESHOLD:
            begin
                width_mask = 32'h0000_00FF;
                cfg_shadow.double_threshold = value[7:0];
            end
            REG_IDLE_LIMIT:
            begin
                width_mask = 32'h0000_FFFF;
                cfg_shadow.idle_limit = value[15:0];
            end
            default:
            begin
                width_mask = 32'h0000_00FF;
                cfg_shadow.device_code = value[7:0];
            end
        endcase
        if ((readback & width_mask) !== (value & width_mask))
        begin
            $display("%0t: register %0d read back expected %0h, got %0h",
                     $time, idx, value & width_mask, readback & width_mask);
            mismatch_count++;
        end
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Compares the report about to be taken with the oldest expectation.
    task automatic check_report();
        result_t want;
        if (expected_reports.size() == 0)
        begin
            $display("%0t: report expected none, got valid=%0b dx=%0h dy=%0h sum=%0h",
                     $time, report_valid, delta_x, delta_y, checksum);
            mismatch_count++;
        end
        else
        begin
            want = expected_reports.pop_front();
            check_field("report_valid", 16'(want.report_valid), 16'(report_valid));
            check_field("click_bits", 16'(want.click_bits), 16'(click_bits));
            check_field("delta_x", 16'(want.delta_x), 16'(delta_x));
            check_field("delta_y", 16'(want.delta_y), 16'(delta_y));
            check_field("sign_bits", 16'(want.sign_bits), 16'(sign_bits));
            check_field("checksum", want.checksum, checksum);
            check_field("fast_mode", 16'(want.fast_mode), 16'(fast_mode));
        end
    endtask

    // Receiver: checks each report taken and drives the stall pattern.
    initial
    begin : report_receiver
        int unsigned run_left;
        int unsigned holdoff_left;
        logic        stall_phase;
        logic        stall_next;
        run_left = 0;
        holdoff_left = 0;
        stall_phase = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && !out_stall)
                check_report();
            @(posedge clk);
            if (holdoff_request != 0)
            begin
                holdoff_left = holdoff_request;
                holdoff_request = 0;
            end
            if (holdoff_left != 0)
            begin
                stall_next = 1'b1;
                holdoff_left--;
            end
            else if (rx_stall_on)
            begin
                if (run_left == 0)
                begin
                    stall_phase = ($urandom_range(0, 2) == 0);
                    run_left = stall_phase ? 1 + pick_pause() : $urandom_range(1, 12);
                end
                run_left--;
                stall_next = stall_phase;
            end
            else
            begin
                stall_next = 1'b0;
            end
            out_stall <= stall_next;
        end
    end

    // Motion, clicks and reports under the reset register values.
    task automatic test_directed_motion();
        tx_gaps_on = 1'b1;
        rx_stall_on = 1'b1;
        // Touchdown at the far corner gives a report with no motion.
        send_scan(scan_item(1'b1, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0));
        // Held touch: X falls by 5, Y rises by 3.
        send_scan(scan_item(1'b1, 16'hFFFA, 16'h0003, 1'b0, 1'b0, 1'b0));
        // A delta equal to the threshold stays as it is; Y unchanged.
        send_scan(scan_item(1'b1, 16'hFFF0, 16'h0003, 1'b0, 1'b0, 1'b0));
        // One above the threshold is doubled; Y falls.
        send_scan(scan_item(1'b1, 16'hFFFB, 16'h0000, 1'b0, 1'b0, 1'b0));
        // Largest jumps both ways.
        send_scan(scan_item(1'b1, 16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b0));
        send_scan(scan_item(1'b1, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0));
        // Doubled deltas whose low byte comes out as zero.
        send_scan(scan_item(1'b1, 16'h007F, 16'h0080, 1'b0, 1'b0, 1'b0));
        // Liftoff clears the position history and gives no report.
        send_scan(scan_item(1'b0, 16'h1234, 16'h5678, 1'b0, 1'b0, 1'b0));
        send_scan(scan_item(1'b1, 16'h0005, 16'h0005, 1'b0, 1'b0, 1'b0));
        send_scan(scan_item(1'b1, 16'h0003, 16'h0007, 1'b0, 1'b0, 1'b0));
        send_scan(scan_item(1'b0, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0));
        // Left click with no finger, then held without a new edge.
        send_scan(scan_item(1'b0, 16'h0F0F, 16'hF0F0, 1'b1, 1'b0, 1'b0));
        send_scan(scan_item(1'b0, 16'hAAAA, 16'h5555, 1'b1, 1'b0, 1'b0));
        // Right click while left stays down.
        send_scan(scan_item(1'b0, 16'h5555, 16'hAAAA, 1'b1, 1'b1, 1'b0));
        // Both released, then both pressed together.
        send_scan(scan_item(1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0));
        send_scan(scan_item(1'b0, 16'h0000, 16'h0000, 1'b1, 1'b1, 1'b0));
        // The ganged sensor alone is activity but gives no report.
        send_scan(scan_item(1'b0, 16'h8000, 16'h7FFF, 1'b0, 1'b0, 1'b1));
        // Everything active at once, then a held touch to the origin.
        send_scan(scan_item(1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1));
        send_scan(scan_item(1'b1, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0));
        send_scan(scan_item(1'b0, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0));
        wait_drained();
    endtask

    // Drop into slow mode after the idle limit and wake on the ganged sensor.
    task automatic test_idle_and_wake();
        tx_gaps_on = 1'b0;
        rx_stall_on = 1'b1;
        // The previous test ended on an idle scan, so these reach the limit; ganged activity then wakes the block.
        repeat (149) send_scan(scan_item(1'b0, rand_position(), rand_position(),
                                         1'b0, 1'b0, 1'b0));
        send_scan(scan_item(1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1));
        repeat (150) send_scan(scan_item(1'b0, rand_position(), rand_position(),
                                         1'b0, 1'b0, 1'b0));
        // Slow mode ignores finger and buttons and keeps the history.
        send_scan(scan_item(1'b1, 16'h1111, 16'h2222, 1'b1, 1'b1, 1'b0));
        send_scan(scan_item(1'b1, 16'h3333, 16'h4444, 1'b0, 1'b1, 1'b0));
        // Wake-up scan gives no report even with the finger down.
        send_scan(scan_item(1'b1, 16'h5555, 16'h6666, 1'b1, 1'b0, 1'b1));
        // Back in fast mode the press is a fresh edge and a touchdown.
        send_scan(scan_item(1'b1, 16'h0100, 16'h0100, 1'b1, 1'b0, 1'b0));
        send_scan(scan_item(1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0));
        // An idle limit of zero drops to slow mode on the first idle scan.
        write_register(REG_IDLE_LIMIT, 32'd0);
        send_scan(scan_item(1'b0, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0));
        send_scan(scan_item(1'b0, 16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b1));
        write_register(REG_IDLE_LIMIT, 32'd1);
        send_scan(scan_item(1'b0, 16'h1234, 16'h4321, 1'b0, 1'b0, 1'b0));
        send_scan(scan_item(1'b0, 16'h4321, 16'h1234, 1'b0, 1'b0, 1'b0));
        send_scan(scan_item(1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1));
        wait_drained();
    endtask

    // The receiver holds off for a long stretch while items keep coming.
    task automatic test_receiver_holdoff();
        logic [15:0] x;
        tx_gaps_on = 1'b0;
        rx_stall_on = 1'b0;
        holdoff_request = 300;
        x = 16'h1000;
        for (int i = 0; i < 12; i++)
        begin
            send_scan(scan_item(1'b1, x, 16'h2000 - 16'(i * 7), i[0], 1'b0, 1'b0));
            x = x + 16'd3;
        end
        wait_drained();
    endtask

    // One random sequence: mostly held gestures, plus clicks, idling and noise.
    task automatic run_random_sequence();
        seq_kind_t   kind;
        int unsigned pick;
        int unsigned len;
        logic [15:0] x;
        logic [15:0] y;
        logic        l;
        logic        r;
        pick = $urandom_range(0, 99);
        kind = (pick < 50) ? SEQ_GESTURE : (pick < 68) ? SEQ_CLICKS :
               (pick < 85) ? SEQ_IDLE_RUN : SEQ_NOISE;
        case (kind)
            SEQ_GESTURE:
            begin
                x = rand_position();
                y = rand_position();
                l = 1'b0;
                r = 1'b0;
                len = $urandom_range(2, 12);
                repeat (len)
                begin
                    if ($urandom_range(0, 6) == 0)
                        l = ~l;
                    if ($urandom_range(0, 6) == 0)
                        r = ~r;
                    send_scan(scan_item(1'b1, x, y, l, r, $urandom_range(0, 9) == 0));
                    x = step_position(x);
                    y = step_position(y);
                end
            end
            SEQ_CLICKS:
            begin
                repeat ($urandom_range(2, 8))
                    send_scan(scan_item($urandom_range(0, 3) == 0, 16'($urandom),
                                        16'($urandom), 1'($urandom_range(0, 1)),
                                        1'($urandom_range(0, 1)),
                                        $urandom_range(0, 7) == 0));
            end
            SEQ_IDLE_RUN:
            begin
                // Long enough to reach slow mode when the limit is small.
                len = (cfg_shadow.idle_limit <= 16'd40) ?
                      cfg_shadow.idle_limit + $urandom_range(0, 3) : $urandom_range(1, 10);
                repeat (len) send_scan(scan_item(1'b0, 16'($urandom), 16'($urandom),
                                                 1'b0, 1'b0, 1'b0));
                repeat ($urandom_range(0, 4))
                    send_scan(scan_item(1'($urandom_range(0, 1)), 16'($urandom),
                                        16'($urandom), 1'($urandom_range(0, 1)),
                                        1'($urandom_range(0, 1)), 1'b0));
                send_scan(scan_item(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                    1'b1));
            end
            default:
            begin
                repeat ($urandom_range(1, 6))
                    send_scan(scan_item(1'($urandom_range(0, 1)), 16'($urandom),
                                        16'($urandom), 1'($urandom_range(0, 1)),
                                        1'($urandom_range(0, 1)),
                                        1'($urandom_range(0, 1))));
            end
        endcase
    endtask

    // Random traffic over several register settings, extremes included.
    task automatic test_random_traffic();
        int unsigned phase_start;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    write_register(REG_THRESHOLD, 32'd0);
                    write_register(REG_IDLE_LIMIT, 32'd1);
                    write_register(REG_DEVICE_CODE, 32'd0);
                    tx_gaps_on = 1'b1;
                    rx_stall_on = 1'b1;
                end
                1:
                begin
                    write_register(REG_THRESHOLD, 32'd255);
                    write_register(REG_IDLE_LIMIT, 32'd65535);
                    write_register(REG_DEVICE_CODE, 32'd255);
                    tx_gaps_on = 1'b0;
                    rx_stall_on = 1'b0;
                end
                2:
                begin
                    write_register(REG_THRESHOLD, $urandom_range(0, 40));
                    write_register(REG_IDLE_LIMIT, $urandom_range(2, 30));
                    write_register(REG_DEVICE_CODE, $urandom_range(0, 255));
                    tx_gaps_on = 1'b1;
                    rx_stall_on = 1'b0;
                end
                3:
                begin
                    write_register(REG_THRESHOLD, 32'd128);
                    write_register(REG_IDLE_LIMIT, 32'd0);
                    write_register(REG_DEVICE_CODE, 32'hAA);
                    tx_gaps_on = 1'b0;
                    rx_stall_on = 1'b1;
                end
                4:
                begin
                    write_register(REG_THRESHOLD, $urandom_range(0, 255));
                    write_register(REG_IDLE_LIMIT, $urandom_range(1, 65535));
                    write_register(REG_DEVICE_CODE, $urandom_range(0, 255));
                    tx_gaps_on = 1'b1;
                    rx_stall_on = 1'b1;
                end
                default:
                begin
                    write_register(REG_THRESHOLD, 32'd10);
                    write_register(REG_IDLE_LIMIT, 32'd150);
                    write_register(REG_DEVICE_CODE, 32'h55);
                    tx_gaps_on = 1'b1;
                    rx_stall_on = 1'b0;
                end
            endcase
            phase_start = scans_sent;
            while (scans_sent - phase_start < 190)
                run_random_sequence();
        end
    endtask

    initial
    begin : main_sequence
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_motion();
        test_idle_and_wake();
        test_receiver_holdoff();
        test_random_traffic();
        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && expected_reports.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== trackpad_relative_motion_reporter_core.f =====
src/trp_pkg.sv
src/trp_regs.sv
src/trp_motion.sv
src/trackpad_relative_motion_reporter_core.sv
verif/tb_trackpad_relative_motion_reporter_core.sv
